// File: hw/rtl/lew3d_pkg.sv
`timescale 1ns / 1ps
// Package for the loop-erased walk unit: word types, codes and fixed widths.
// No dependencies; used by loop_erased_walk_3d_unit.
package lew3d_pkg;

	localparam int LEN_OUT_W      = 19;
	localparam int LOOP_OUT_W     = 32;
	localparam int SCALE_W        = 4;
	localparam int LIMIT_W        = 4;
	localparam int MIN_SCALE_LOG2 = 3;
	localparam int LIMIT_RESET    = 5;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic CFG_IDX_LIMIT = 1'b0;

	localparam logic FUNC_STEP    = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	localparam logic [2:0] DIR_POS_X = 3'd0;
	localparam logic [2:0] DIR_POS_Y = 3'd1;
	localparam logic [2:0] DIR_POS_Z = 3'd2;
	localparam logic [2:0] DIR_NEG_Z = 3'd3;
	localparam logic [2:0] DIR_NEG_Y = 3'd4;
	localparam logic [2:0] DIR_NEG_X = 3'd5;

	typedef struct packed {
		logic       func;
		logic [2:0] direction;
	} step_t;

	typedef struct packed {
		logic [LEN_OUT_W-1:0]  erased_length;
		logic [LOOP_OUT_W-1:0] loop_steps;
		logic [SCALE_W-1:0]    crossed_scale;
		logic                  walk_done;
	} result_t;

endpackage

// File: hw/rtl/lew3d_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module lew3d_ram #(
	parameter int WIDTH = 1,
	parameter longint unsigned DEPTH = 2,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/loop_erased_walk_3d_unit.sv
`timescale 1ns / 1ps
// Loop-erased random walk on a cubic lattice, one step per input word.
// Depends on lew3d_pkg and lew3d_ram (visited bitmap and path stack).
//
// After reset the unit runs a clearing pass over the visited bitmap, one
// site per cycle, (2*2^RADIUS_LOG2+1)^3 sites in all (274625 by default),
// and holds step_ready low until it ends. A step onto a free site passes
// through S_LOOKUP, where the visited bitmap is read, modified and written,
// and S_FIN before the next word can be accepted. A step that closes a loop
// goes on from S_LOOKUP to S_POP, where the path stack is read once per
// popped site and once more for the entry that ends the loop; a loop that
// ends at the origin needs no such last read. A restart unwinds the current
// path site by site in S_POP to unmark the bitmap. An ignored step goes
// straight to S_FIN. A finished result waits in an output register while
// the next word is accepted.
module loop_erased_walk_3d_unit #(
	parameter int RADIUS_LOG2 = 5,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_valid,
	output logic                                step_ready,
	input  lew3d_pkg::step_t                    step_word,
	output logic                                result_valid,
	input  logic                                result_ready,
	output lew3d_pkg::result_t                  result_word,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lew3d_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [lew3d_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [lew3d_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                pready
);

	localparam longint unsigned RAD      = 64'd1 << RADIUS_LOG2;
	localparam longint unsigned SIDE     = 2 * RAD + 1;
	localparam longint unsigned SITES    = SIDE * SIDE * SIDE;
	localparam longint unsigned ORIGIN   = RAD * SIDE * SIDE + RAD * SIDE + RAD;
	localparam longint unsigned STRIDE_X = SIDE * SIDE;
	localparam longint unsigned STRIDE_Y = SIDE;
	localparam int SITE_W  = $clog2(SITES);
	localparam int LEN_W   = SITE_W;
	localparam int COORD_W = RADIUS_LOG2 + 2;
	localparam int MAG_W   = RADIUS_LOG2 + 1;
	localparam int WIDE_W  = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;
	localparam int DIFF_W  = (WIDE_W > lew3d_pkg::LOOP_OUT_W) ? WIDE_W : lew3d_pkg::LOOP_OUT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_POP,
		S_FIN
	} state_t;

	state_t state_q;

	logic [lew3d_pkg::LIMIT_W-1:0] limit_q;
	logic signed [COORD_W-1:0]     hx_q, hy_q, hz_q;
	logic [SITE_W-1:0]             idx_q;
	logic [SITE_W-1:0]             clr_q;
	logic [LEN_W-1:0]              len_q;
	logic [COUNT_WIDTH-1:0]        total_q;
	logic [lew3d_pkg::SCALE_W-1:0] highest_q;
	logic [lew3d_pkg::SCALE_W-1:0] crossed_q;
	logic                          finished_q;
	logic                          restart_q;
	logic                          out_valid_q;
	lew3d_pkg::result_t            out_q;

	logic signed [COORD_W-1:0]     nx, ny, nz;
	logic [SITE_W-1:0]             nidx;
	logic [MAG_W-1:0]              ax, ay, az, mag;
	logic [lew3d_pkg::SCALE_W-1:0] lg;
	logic [lew3d_pkg::LIMIT_W-1:0] lim_eff;
	logic                          scale_hit;
	logic                          reach;
	logic                          step_acc;
	logic                          cfg_wr;
	logic                          push_ok;
	logic                          pop_match;
	logic                          out_load;
	logic [DIFF_W-1:0]             diff;

	logic              vis_we;
	logic [SITE_W-1:0] vis_waddr;
	logic              vis_wdata;
	logic              vis_rdata;
	logic              stk_we;
	logic [SITE_W-1:0] stk_waddr;
	logic [SITE_W-1:0] stk_raddr;
	logic [SITE_W-1:0] stk_rdata;

	assign step_ready   = (state_q == S_IDLE);
	assign step_acc     = step_valid && step_ready;
	assign result_valid = out_valid_q;
	assign result_word  = out_q;
	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite && (paddr[2] == lew3d_pkg::CFG_IDX_LIMIT);

	always_comb begin
		prdata = '0;
		if (paddr[2] == lew3d_pkg::CFG_IDX_LIMIT) begin
			prdata = lew3d_pkg::CFG_DATA_W'(limit_q);
		end
	end

	always_comb begin
		nx   = hx_q;
		ny   = hy_q;
		nz   = hz_q;
		nidx = idx_q;
		case (step_word.direction)
			lew3d_pkg::DIR_POS_X: begin
				nx   = hx_q + COORD_W'(1);
				nidx = idx_q + SITE_W'(STRIDE_X);
			end
			lew3d_pkg::DIR_POS_Y: begin
				ny   = hy_q + COORD_W'(1);
				nidx = idx_q + SITE_W'(STRIDE_Y);
			end
			lew3d_pkg::DIR_POS_Z: begin
				nz   = hz_q + COORD_W'(1);
				nidx = idx_q + SITE_W'(1);
			end
			lew3d_pkg::DIR_NEG_Z: begin
				nz   = hz_q - COORD_W'(1);
				nidx = idx_q - SITE_W'(1);
			end
			lew3d_pkg::DIR_NEG_Y: begin
				ny   = hy_q - COORD_W'(1);
				nidx = idx_q - SITE_W'(STRIDE_Y);
			end
			lew3d_pkg::DIR_NEG_X: begin
				nx   = hx_q - COORD_W'(1);
				nidx = idx_q - SITE_W'(STRIDE_X);
			end
			default: begin
				nidx = idx_q;
			end
		endcase
	end

	always_comb begin
		ax  = nx[COORD_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
		ay  = ny[COORD_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
		az  = nz[COORD_W-1] ? MAG_W'(-nz) : MAG_W'(nz);
		mag = ax;
		if (ay > mag) begin
			mag = ay;
		end
		if (az > mag) begin
			mag = az;
		end
		lg = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag[i]) begin
				lg = lew3d_pkg::SCALE_W'(i);
			end
		end
		scale_hit = (lg >= lew3d_pkg::SCALE_W'(lew3d_pkg::MIN_SCALE_LOG2))
			&& ((lg - lew3d_pkg::SCALE_W'(2)) > highest_q);
		if (limit_q < lew3d_pkg::LIMIT_W'(lew3d_pkg::MIN_SCALE_LOG2)) begin
			lim_eff = lew3d_pkg::LIMIT_W'(lew3d_pkg::MIN_SCALE_LOG2);
		end else if (limit_q > lew3d_pkg::LIMIT_W'(RADIUS_LOG2)) begin
			lim_eff = lew3d_pkg::LIMIT_W'(RADIUS_LOG2);
		end else begin
			lim_eff = limit_q;
		end
		reach = (mag >> lim_eff) != '0;
	end

	assign push_ok   = ({1'b0, len_q} + (LEN_W + 1)'(1)) < (LEN_W + 1)'(SITES);
	assign pop_match = !restart_q && (stk_rdata == idx_q);
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || result_ready);
	assign diff      = DIFF_W'(total_q) - DIFF_W'(len_q);
	assign stk_raddr = (state_q == S_POP) ? (len_q - LEN_W'(1)) : len_q;

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = idx_q;
		vis_wdata = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = len_q + LEN_W'(1);
		case (state_q)
			S_CLEAR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_q;
				vis_wdata = (clr_q == SITE_W'(ORIGIN));
			end
			S_LOOKUP: begin
				if (!vis_rdata && push_ok) begin
					vis_we    = 1'b1;
					vis_wdata = 1'b1;
					stk_we    = 1'b1;
				end
			end
			S_POP: begin
				if (!pop_match) begin
					vis_we    = 1'b1;
					vis_waddr = stk_rdata;
				end
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	lew3d_ram #(
		.WIDTH (1),
		.DEPTH (SITES)
	) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (nidx),
		.rdata (vis_rdata)
	);

	lew3d_ram #(
		.WIDTH (SITE_W),
		.DEPTH (SITES)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (idx_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			limit_q     <= lew3d_pkg::LIMIT_W'(lew3d_pkg::LIMIT_RESET);
			hx_q        <= '0;
			hy_q        <= '0;
			hz_q        <= '0;
			idx_q       <= SITE_W'(ORIGIN);
			clr_q       <= '0;
			len_q       <= '0;
			total_q     <= '0;
			highest_q   <= '0;
			crossed_q   <= '0;
			finished_q  <= 1'b0;
			restart_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				limit_q <= pwdata[lew3d_pkg::LIMIT_W-1:0];
			end
			if (out_valid_q && result_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SITE_W'(1);
					if (clr_q == SITE_W'(SITES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (step_acc) begin
						if (step_word.func == lew3d_pkg::FUNC_RESTART) begin
							hx_q       <= '0;
							hy_q       <= '0;
							hz_q       <= '0;
							idx_q      <= SITE_W'(ORIGIN);
							total_q    <= '0;
							highest_q  <= '0;
							crossed_q  <= '0;
							finished_q <= 1'b0;
							restart_q  <= 1'b1;
							state_q    <= (len_q == '0) ? S_FIN : S_POP;
						end else if (finished_q
							|| step_word.direction > lew3d_pkg::DIR_NEG_X) begin
							crossed_q <= '0;
							restart_q <= 1'b0;
							state_q   <= S_FIN;
						end else begin
							hx_q      <= nx;
							hy_q      <= ny;
							hz_q      <= nz;
							idx_q     <= nidx;
							restart_q <= 1'b0;
							if (total_q != '1) begin
								total_q <= total_q + COUNT_WIDTH'(1);
							end
							if (scale_hit) begin
								highest_q <= lg - lew3d_pkg::SCALE_W'(2);
								crossed_q <= lg - lew3d_pkg::SCALE_W'(2);
							end else begin
								crossed_q <= '0;
							end
							if (reach) begin
								finished_q <= 1'b1;
							end
							state_q <= S_LOOKUP;
						end
					end
				end
				S_LOOKUP: begin
					if (!vis_rdata) begin
						if (push_ok) begin
							len_q <= len_q + LEN_W'(1);
						end
						state_q <= S_FIN;
					end else if (len_q == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_POP;
					end
				end
				S_POP: begin
					if (pop_match) begin
						state_q <= S_FIN;
					end else begin
						len_q <= len_q - LEN_W'(1);
						if (len_q == LEN_W'(1)) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.erased_length <= lew3d_pkg::LEN_OUT_W'(len_q);
			out_q.loop_steps    <= lew3d_pkg::LOOP_OUT_W'(diff);
			out_q.crossed_scale <= crossed_q;
			out_q.walk_done     <= finished_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_restart_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && restart_q |-> len_q == '0 && total_q == '0)
		else $error("restart result with a nonempty path");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> len_q != '0)
		else $error("pop on an empty path stack");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && !(step_acc && step_word.func == lew3d_pkg::FUNC_RESTART)
		|=> finished_q)
		else $error("walk end lost without a restart");
`endif

endmodule
